@@ rtl/core/coe_pkg.sv @@
// Shared types and codes for the clock offset estimator.
`default_nettype none

package coe_pkg;

  localparam int unsigned TS_W = 64;

  typedef enum logic [1:0] {
    ACT_SYNC      = 2'd0,
    ACT_TO_LOCAL  = 2'd1,
    ACT_TO_REMOTE = 2'd2,
    ACT_NONE      = 2'd3
  } coe_action_e;

  // Controller-to-datapath commands, one per sequencer step.
  typedef struct packed {
    logic load;
    logic diff;
    logic off;
    logic acc;
    logic div_init;
    logic div_step;
    logic fin;
    logic conv;
    logic emit;
  } coe_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/coe_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module coe_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/coe_datapath.sv @@
// Datapath: timestamp differences, offset history, running sum, divider, conversion.
`default_nettype none

module coe_datapath #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned SUM_W = 68
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire coe_pkg::coe_cmd_t cmd_i,
  input  wire logic [1:0]       in_action_i,
  input  wire logic [319:0]     in_data_i,
  output logic      [191:0]     out_data_o
);

  localparam int unsigned SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  coe_pkg::coe_action_e act_q;
  logic [63:0] t0_q, t1_q, t2_q, t3_q, tv_q;
  logic [63:0] diff_a_q, diff_b_q, delay_q, off_q, conv_q;
  logic [SUM_W-1:0] quo_q;
  logic [CNT_W-1:0] rem_q;
  logic             neg_q;
  logic [191:0]     out_q;

  logic [SLOT_W-1:0] slot_q;
  logic [CNT_W-1:0]  fill_q;
  logic [SUM_W-1:0]  sum_q;
  logic [63:0]       mean_q, round_trip_q;

  logic [63:0] ram_rdata;
  logic [63:0] old_off;
  logic        full;
  logic [64:0] off_sum;
  logic [63:0] off_d;
  logic [CNT_W:0]   shifted;
  logic [CNT_W+1:0] trial;

  coe_ram #(
    .WIDTH(64),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (cmd_i.acc),
    .waddr_i(slot_q),
    .wdata_i(off_q),
    .re_i   (cmd_i.diff),
    .raddr_i(slot_q),
    .rdata_o(ram_rdata)
  );

  // Entries never written read as zero: before the ring is full the slot is fresh.
  assign full    = (fill_q == CNT_W'(DEPTH));
  assign old_off = full ? ram_rdata : 64'd0;

  // Half of a 65-bit signed sum, rounded toward zero.
  assign off_sum = {diff_a_q[63], diff_a_q} + {diff_b_q[63], diff_b_q};
  assign off_d   = off_sum[64:1] + 64'(off_sum[64] & off_sum[0]);

  assign shifted = {rem_q, quo_q[SUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, fill_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= coe_pkg::coe_action_e'(in_action_i);
      t0_q  <= in_data_i[63:0];
      t1_q  <= in_data_i[127:64];
      t2_q  <= in_data_i[191:128];
      t3_q  <= in_data_i[255:192];
      tv_q  <= in_data_i[319:256];
    end
    if (cmd_i.diff) begin
      diff_a_q <= t1_q - t0_q;
      diff_b_q <= t2_q - t3_q;
      delay_q  <= (t3_q - t0_q) - (t2_q - t1_q);
    end
    if (cmd_i.off) begin
      off_q <= off_d;
    end
    if (cmd_i.div_init) begin
      neg_q <= sum_q[SUM_W-1];
      quo_q <= sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      quo_q <= {quo_q[SUM_W-2:0], ~trial[CNT_W+1]};
      rem_q <= trial[CNT_W+1] ? shifted[CNT_W-1:0] : trial[CNT_W-1:0];
    end
    if (cmd_i.fin) begin
      conv_q <= 64'd0;
    end
    if (cmd_i.conv) begin
      unique case (act_q)
        coe_pkg::ACT_TO_LOCAL:  conv_q <= tv_q - mean_q;
        coe_pkg::ACT_TO_REMOTE: conv_q <= tv_q + mean_q;
        default:                conv_q <= 64'd0;
      endcase
    end
    if (cmd_i.emit) begin
      out_q <= {conv_q, round_trip_q, mean_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q       <= '0;
      fill_q       <= '0;
      sum_q        <= '0;
      mean_q       <= '0;
      round_trip_q <= '0;
    end else begin
      if (cmd_i.acc) begin
        sum_q <= sum_q + {{(SUM_W-64){off_q[63]}}, off_q}
                       - {{(SUM_W-64){old_off[63]}}, old_off};
        round_trip_q <= delay_q;
        slot_q <= (slot_q == SLOT_W'(DEPTH - 1)) ? '0 : slot_q + 1'b1;
        if (!full) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (cmd_i.fin) begin
        mean_q <= neg_q ? (64'd0 - quo_q[63:0]) : quo_q[63:0];
      end
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

@@ rtl/core/coe_ctrl.sv @@
// Controller: sequences one item through the datapath and owns the output valid.
`default_nettype none

module coe_ctrl #(
  parameter int unsigned SUM_W = 68
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [1:0]       in_action_i,
  output logic                  in_ready_o,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output coe_pkg::coe_cmd_t     cmd_o
);

  localparam int unsigned STEP_W = $clog2(SUM_W);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_OFF,
    S_ACC,
    S_DINIT,
    S_DIV,
    S_FIN,
    S_CONV,
    S_EMIT
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic              out_valid_q;
  logic              accept;
  logic              emit;

  assign accept = (state_q == S_IDLE) && in_valid_i;
  assign emit   = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= (coe_pkg::coe_action_e'(in_action_i) == coe_pkg::ACT_SYNC) ?
                       S_DIFF : S_CONV;
          end
        end
        S_DIFF:  state_q <= S_OFF;
        S_OFF:   state_q <= S_ACC;
        S_ACC:   state_q <= S_DINIT;
        S_DINIT: begin
          step_q  <= STEP_W'(SUM_W - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          step_q <= step_q - 1'b1;
          if (step_q == '0) begin
            state_q <= S_FIN;
          end
        end
        S_FIN:  state_q <= S_EMIT;
        S_CONV: state_q <= S_EMIT;
        S_EMIT: begin
          if (emit) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = accept;
    cmd_o.diff     = (state_q == S_DIFF);
    cmd_o.off      = (state_q == S_OFF);
    cmd_o.acc      = (state_q == S_ACC);
    cmd_o.div_init = (state_q == S_DINIT);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.fin      = (state_q == S_FIN);
    cmd_o.conv     = (state_q == S_CONV);
    cmd_o.emit     = emit;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/core/clock_offset_estimator.sv @@
// Clock offset estimator: NTP-style offset and delay with a moving average of the offset.
//
// Input stream (s_axis): tuser carries the action, tdata the four sync timestamps and
// the time value to convert. Output stream (m_axis): one beat per input beat with the
// averaged offset, the delay of the latest sync sample and the converted time.
// One item is in work at a time; s_axis_tready is high only while the sequencer is idle.
// Path from the accepting edge to the edge that raises output valid:
//   convert or unused action: the convert state, then the emit state
//   sync sample: difference, offset, accumulate, divider init, divide, finish, emit,
//   with SUM_W = 65 + clog2(HISTORY_DEPTH) (68 at depth 8); the divide state runs the
//   restoring divider, which retires one quotient bit per cycle.
// The output beat sits in its own register, so the next item is accepted while a
// finished beat waits on m_axis_tready; a stalled receiver only holds the sequencer
// once that next result is ready to be written.
// Reset clears the fill count, running sum, averaged offset and delay; history entries
// not yet written count as zero through the fill count, so no clearing pass is needed.
`default_nettype none

module clock_offset_estimator #(
  parameter int unsigned HISTORY_DEPTH = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [63:0] client_send_us, [127:64] server_recv_us, [191:128] server_send_us,
  // [255:192] client_recv_us, [319:256] time_value_us
  input  wire logic [319:0] s_axis_tdata,
  // [1:0] action
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [63:0] avg_offset_us, [127:64] last_delay_us, [191:128] converted_us
  output logic      [191:0] m_axis_tdata
);

  localparam int unsigned SUM_W = 65 + $clog2(HISTORY_DEPTH);

  coe_pkg::coe_cmd_t cmd;

  coe_ctrl #(
    .SUM_W(SUM_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_action_i(s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .cmd_o      (cmd)
  );

  coe_datapath #(
    .DEPTH(HISTORY_DEPTH),
    .SUM_W(SUM_W)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_action_i(s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ rtl/core/coe_checker.sv @@
// Port-level checks for the clock offset estimator, bound to the top level.
`default_nettype none

module coe_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [191:0] m_axis_tdata
);

  // Only one item in work: an accept drops ready on the next cycle.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  // A new output beat is produced only while the sequencer is busy.
  a_emit_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("output beat appeared without an item in work");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output valid dropped before the beat was taken");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("output data changed while stalled");

endmodule

bind clock_offset_estimator coe_checker u_coe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
